### src/numeric_literal_classifier_top_assert.svh
// assertion macros for the numeric literal classifier
`ifndef NUMERIC_LITERAL_CLASSIFIER_TOP_ASSERT_SVH
`define NUMERIC_LITERAL_CLASSIFIER_TOP_ASSERT_SVH

// checked only while out of reset
`define NLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NLC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/nlc_pkg.sv
// types and constant tables for the numeric literal classifier
package nlc_pkg;

    localparam int PSEUDO_COUNT = 6;
    localparam int POS_MAX      = 7;

    typedef enum logic [2:0] {
        CLS_INVALID = 3'd0,
        CLS_CHAR    = 3'd1,
        CLS_INT     = 3'd2,
        CLS_FLOAT   = 3'd3,
        CLS_DOUBLE  = 3'd4,
        CLS_PSEUDO  = 3'd5
    } class_t;

    // pseudo spellings, zero padded to the eight positions of the counter
    localparam logic [7:0] PSEUDO_TEXT [PSEUDO_COUNT][8] = '{
        '{8'h2d, 8'h69, 8'h6e, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00},
        '{8'h2b, 8'h69, 8'h6e, 8'h66, 8'h66, 8'h00, 8'h00, 8'h00},
        '{8'h6e, 8'h61, 8'h6e, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2d, 8'h69, 8'h6e, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2b, 8'h69, 8'h6e, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6e, 8'h61, 8'h6e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] PSEUDO_LEN [PSEUDO_COUNT] = '{
        3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3
    };

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

### src/numeric_literal_classifier_top.sv
// an item's class is registered after its last byte passes the byte register
// throughput: one byte per cycle, sustained, with a free or draining result slot
// the byte register and the flag update form a single pass, no iteration
// ready drops only when a last byte waits on a stalled result register
// rst_n resets all flags, the position counter and both valid bits at once
module numeric_literal_classifier_top
    import nlc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] literal_class
);

    `include "numeric_literal_classifier_top_assert.svh"

    // input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    // running flags
    logic [2:0]              pos_reg;
    logic [PSEUDO_COUNT-1:0] mask_reg;
    logic                    only_num_reg;
    logic                    only_int_reg;
    logic                    digit_seen_reg;
    logic                    minus_bad_reg;
    logic [1:0]              dot_count_reg;
    logic                    prev_dig_reg;
    logic [1:0]              sides_reg;
    logic                    after_dot_reg;
    logic [1:0]              f_count_reg;

    // result register
    logic   out_valid_reg;
    class_t class_reg;

    logic                    advance;
    logic                    is_dig;
    logic                    is_int;
    logic                    is_num;
    logic [PSEUDO_COUNT-1:0] mask_next;
    logic                    only_num_next;
    logic                    only_int_next;
    logic                    digit_seen_next;
    logic                    minus_bad_next;
    logic [1:0]              dot_count_next;
    logic [1:0]              sides_next;
    logic                    after_dot_next;
    logic [1:0]              f_count_next;
    logic                    pseudo_hit;
    logic                    dot_ok;
    class_t                  class_next;

    // a non-last byte never needs the result slot
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        is_dig = (byte_reg >= CH_ZERO) && (byte_reg <= CH_NINE);
        is_int = is_dig || (byte_reg == CH_MINUS);
        is_num = is_int || (byte_reg == CH_DOT) || (byte_reg == CH_F);

        pseudo_hit = 1'b0;
        for (int k = 0; k < PSEUDO_COUNT; k++)
        begin
            mask_next[k] = mask_reg[k] && (pos_reg < PSEUDO_LEN[k])
                           && (PSEUDO_TEXT[k][pos_reg] == byte_reg);
            if (mask_next[k] && ({1'b0, pos_reg} + 4'd1 == {1'b0, PSEUDO_LEN[k]}))
                pseudo_hit = 1'b1;
        end

        only_num_next   = only_num_reg && is_num;
        only_int_next   = only_int_reg && is_int;
        digit_seen_next = digit_seen_reg || is_dig;
        minus_bad_next  = minus_bad_reg || ((byte_reg == CH_MINUS) && (pos_reg != 3'd0));

        sides_next     = sides_reg;
        after_dot_next = after_dot_reg;
        dot_count_next = dot_count_reg;
        if (after_dot_reg)
        begin
            if (is_dig)
                sides_next[1] = 1'b1;
            after_dot_next = 1'b0;
        end
        if (byte_reg == CH_DOT)
        begin
            if (dot_count_reg == 2'd0)
            begin
                if (prev_dig_reg)
                    sides_next[0] = 1'b1;
                after_dot_next = 1'b1;
            end
            if (dot_count_reg != 2'd2)
                dot_count_next = dot_count_reg + 2'd1;
        end

        f_count_next = f_count_reg;
        if ((byte_reg == CH_F) && (f_count_reg != 2'd2))
            f_count_next = f_count_reg + 2'd1;

        dot_ok = (dot_count_next == 2'd1) && (sides_next == 2'b11);

        class_next = CLS_INVALID;
        if ((pos_reg == 3'd0) && !is_dig)
            class_next = CLS_CHAR;
        else if (pseudo_hit)
            class_next = CLS_PSEUDO;
        else if (only_num_next && digit_seen_next && !minus_bad_next)
        begin
            if (only_int_next)
                class_next = CLS_INT;
            else if (f_count_next != 2'd0)
                class_next = ((f_count_next == 2'd1) && (byte_reg == CH_F) && dot_ok)
                             ? CLS_FLOAT : CLS_INVALID;
            else
                class_next = dot_ok ? CLS_DOUBLE : CLS_INVALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= char_byte;
            last_reg <= last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            mask_reg       <= '1;
            only_num_reg   <= 1'b1;
            only_int_reg   <= 1'b1;
            digit_seen_reg <= 1'b0;
            minus_bad_reg  <= 1'b0;
            dot_count_reg  <= '0;
            prev_dig_reg   <= 1'b0;
            sides_reg      <= '0;
            after_dot_reg  <= 1'b0;
            f_count_reg    <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                // literal done, start the next one clean
                pos_reg        <= '0;
                mask_reg       <= '1;
                only_num_reg   <= 1'b1;
                only_int_reg   <= 1'b1;
                digit_seen_reg <= 1'b0;
                minus_bad_reg  <= 1'b0;
                dot_count_reg  <= '0;
                prev_dig_reg   <= 1'b0;
                sides_reg      <= '0;
                after_dot_reg  <= 1'b0;
                f_count_reg    <= '0;
            end
            else
            begin
                if (pos_reg != 3'(POS_MAX))
                    pos_reg <= pos_reg + 3'd1;
                mask_reg       <= mask_next;
                only_num_reg   <= only_num_next;
                only_int_reg   <= only_int_next;
                digit_seen_reg <= digit_seen_next;
                minus_bad_reg  <= minus_bad_next;
                dot_count_reg  <= dot_count_next;
                prev_dig_reg   <= is_dig;
                sides_reg      <= sides_next;
                after_dot_reg  <= after_dot_next;
                f_count_reg    <= f_count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last_reg)
            class_reg <= class_next;
    end

    assign out_valid     = out_valid_reg;
    assign literal_class = class_reg;

    `NLC_ASSERT(a_class_range, out_valid_reg |-> (class_reg == CLS_INVALID ||
        class_reg == CLS_CHAR || class_reg == CLS_INT || class_reg == CLS_FLOAT ||
        class_reg == CLS_DOUBLE || class_reg == CLS_PSEUDO), "class code out of range")
    `NLC_ASSERT(a_last_gives_result, (advance && last_reg) |=> out_valid_reg,
        "last byte left no result")
    `NLC_ASSERT(a_flags_clear, (advance && last_reg) |=> (pos_reg == 3'd0 &&
        mask_reg == '1 && dot_count_reg == 2'd0 && f_count_reg == 2'd0),
        "flags not cleared after literal")
    `NLC_ASSERT(a_pos_step, (advance && !last_reg && pos_reg != 3'(POS_MAX)) |=>
        (pos_reg == $past(pos_reg) + 3'd1), "position counter missed a byte")
    `NLC_ASSERT(a_count_sat, (dot_count_reg != 2'd3) && (f_count_reg != 2'd3),
        "dot or f count past saturation")
    `NLC_ASSERT_ALWAYS(a_reset_clear, (!rst_n) |=> (!out_valid_reg && !in_valid_reg),
        "valid bits not cleared by reset")

endmodule

### tb/tb_numeric_literal_classifier_top.sv
// self-checking testbench for the numeric literal classifier top level
module tb_numeric_literal_classifier_top;
    import nlc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int IDLE_LIMIT     = 5000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER  = 150;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } text_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_byte = 8'h00;
    logic       last_char = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] literal_class;

    text_item_t text_stream[$];
    class_t     class_expected[$];
    logic [7:0] literal_buf[$];
    int         error_count = 0;
    int         random_items = 0;

    // predictor copy of the running literal state
    logic [2:0] pos_cnt;
    logic [5:0] spell_live;
    logic       all_numeric;
    logic       all_integer;
    logic       saw_digit;
    logic       bad_minus;
    logic [1:0] dots;
    logic       last_was_digit;
    logic [1:0] dot_neighbors;
    logic       dot_follow_due;
    logic [1:0] fs;

    numeric_literal_classifier_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_byte     (char_byte),
        .last_char     (last_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .literal_class (literal_class)
    );

    always #2 clk = ~clk;

    function automatic string pseudo_spelling(input int k);
        case (k)
            0: return "-inff";
            1: return "+inff";
            2: return "nanf";
            3: return "-inf";
            4: return "+inf";
            default: return "nan";
        endcase
    endfunction

    task automatic clear_literal_state();
        pos_cnt        = 3'd0;
        spell_live     = 6'h3f;
        all_numeric    = 1'b1;
        all_integer    = 1'b1;
        saw_digit      = 1'b0;
        bad_minus      = 1'b0;
        dots           = 2'd0;
        last_was_digit = 1'b0;
        dot_neighbors  = 2'd0;
        dot_follow_due = 1'b0;
        fs             = 2'd0;
    endtask

    // advance the literal state by one byte, queue a class on the last byte
    task automatic classify_byte(input logic [7:0] b, input logic last);
        logic [2:0] p;
        logic       dig;
        logic       intc;
        logic       numc;
        logic       is_pseudo;
        logic       dot_good;
        class_t     cls;
        string      s;
        int         k;
        p    = pos_cnt;
        dig  = (b >= "0") && (b <= "9");
        intc = dig || (b == "-");
        numc = intc || (b == ".") || (b == "f");
        for (k = 0; k < PSEUDO_COUNT; k++)
        begin
            s = pseudo_spelling(k);
            if (int'(p) >= s.len())
                spell_live[k] = 1'b0;
            else if (s[p] != b)
                spell_live[k] = 1'b0;
        end
        all_numeric = all_numeric & numc;
        all_integer = all_integer & intc;
        if (dig)
            saw_digit = 1'b1;
        if (b == "-" && p != 3'd0)
            bad_minus = 1'b1;
        if (dot_follow_due)
        begin
            if (dig)
                dot_neighbors[1] = 1'b1;
            dot_follow_due = 1'b0;
        end
        if (b == ".")
        begin
            if (dots == 2'd0)
            begin
                if (last_was_digit)
                    dot_neighbors[0] = 1'b1;
                dot_follow_due = 1'b1;
            end
            if (dots < 2'd2)
                dots = dots + 2'd1;
        end
        if (b == "f" && fs < 2'd2)
            fs = fs + 2'd1;
        last_was_digit = dig;
        if (pos_cnt < 3'd7)
            pos_cnt = pos_cnt + 3'd1;
        if (last)
        begin
            is_pseudo = 1'b0;
            for (k = 0; k < PSEUDO_COUNT; k++)
            begin
                s = pseudo_spelling(k);
                if (spell_live[k] && int'(p) + 1 == s.len())
                    is_pseudo = 1'b1;
            end
            dot_good = (dots == 2'd1) && (dot_neighbors == 2'b11);
            cls = CLS_INVALID;
            if (p == 3'd0 && !dig)
                cls = CLS_CHAR;
            else if (is_pseudo)
                cls = CLS_PSEUDO;
            else if (all_numeric && saw_digit && !bad_minus)
            begin
                if (all_integer)
                    cls = CLS_INT;
                else if (fs != 2'd0)
                    cls = (fs == 2'd1 && b == "f" && dot_good) ? CLS_FLOAT : CLS_INVALID;
                else
                    cls = dot_good ? CLS_DOUBLE : CLS_INVALID;
            end
            class_expected.push_back(cls);
            clear_literal_state();
        end
    endtask

    // stimulus building
    task automatic push_byte(input logic [7:0] b, input logic last);
        text_item_t it;
        it.char_byte = b;
        it.last_char = last;
        text_stream.push_back(it);
    endtask

    task automatic emit_literal();
        int i;
        for (i = 0; i < literal_buf.size(); i++)
            push_byte(literal_buf[i], i == literal_buf.size() - 1);
        random_items += literal_buf.size();
        literal_buf.delete();
    endtask

    task automatic emit_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endtask

    task automatic add_digits(input int lo, input int hi);
        int n;
        int i;
        n = $urandom_range(hi, lo);
        for (i = 0; i < n; i++)
            literal_buf.push_back(8'h30 + 8'($urandom_range(9, 0)));
    endtask

    // 0 int, 1 float, 2 double
    task automatic build_number(input int kind);
        if ($urandom_range(2, 0) == 0)
            literal_buf.push_back("-");
        if (kind == 0)
        begin
            if ($urandom_range(9, 0) == 0)
                add_digits(7, 12);
            else
                add_digits(1, 6);
        end
        else
        begin
            add_digits(1, 3);
            literal_buf.push_back(".");
            add_digits(1, 3);
            if (kind == 1)
                literal_buf.push_back("f");
        end
    endtask

    function automatic logic [7:0] tricky_byte();
        case ($urandom_range(9, 0))
            0: return "-";
            1: return ".";
            2: return "f";
            3: return "+";
            4: return "n";
            5: return "i";
            6: return 8'h00;
            7: return 8'h30 + 8'($urandom_range(9, 0));
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic mutate_literal();
        int pos;
        int n;
        n   = literal_buf.size();
        pos = $urandom_range(n - 1, 0);
        case ($urandom_range(4, 0))
            0: literal_buf[pos] = tricky_byte();
            1: literal_buf.insert(pos, tricky_byte());
            2: if (n > 1) literal_buf.delete(n - 1);
            3: literal_buf.insert(pos, literal_buf[pos]);
            default: literal_buf.push_back(tricky_byte());
        endcase
    endtask

    task automatic fill_stimulus();
        int kind;
        int n;
        int i;
        string s;
        // directed literals
        emit_str("7");
        emit_str("a");
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        emit_str("-");
        emit_str(".");
        emit_str("f");
        for (i = 0; i < PSEUDO_COUNT; i++)
            emit_str(pseudo_spelling(i));
        emit_str("-1234567890123");
        emit_str("1.5f");
        emit_str("-90.07");
        emit_str("--1");
        emit_str("1-2");
        emit_str("12.");
        emit_str(".5");
        emit_str("1f.5");
        emit_str("1.5ff");
        emit_str("1.2.3");
        push_byte("1", 1'b0);
        push_byte(8'h00, 1'b1);
        emit_str("nanq");
        emit_str("-inffx");
        emit_str("inf");
        // random literals
        while (random_items < RANDOM_ITEMS)
        begin
            kind = $urandom_range(9, 0);
            case (kind)
                0, 1: build_number(0);
                2, 3: build_number(1);
                4: build_number(2);
                5:
                begin
                    s = pseudo_spelling($urandom_range(PSEUDO_COUNT - 1, 0));
                    for (i = 0; i < s.len(); i++)
                        literal_buf.push_back(s[i]);
                end
                6: literal_buf.push_back(8'($urandom_range(255, 0)));
                7:
                begin
                    n = $urandom_range(10, 1);
                    for (i = 0; i < n; i++)
                        literal_buf.push_back(8'($urandom_range(255, 0)));
                end
                default:
                begin
                    if ($urandom_range(3, 0) == 0)
                    begin
                        s = pseudo_spelling($urandom_range(PSEUDO_COUNT - 1, 0));
                        for (i = 0; i < s.len(); i++)
                            literal_buf.push_back(s[i]);
                    end
                    else
                        build_number($urandom_range(2, 0));
                    mutate_literal();
                end
            endcase
            emit_literal();
        end
    endtask

    // sender: bursts with random gaps
    int burst_left = 1;
    int gap_left = 0;
    text_item_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            char_byte  <= 8'h00;
            last_char  <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                classify_byte(char_byte, last_char);
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (text_stream.size() > 0)
                begin
                    next_item = text_stream.pop_front();
                    in_valid  <= 1'b1;
                    char_byte <= next_item.char_byte;
                    last_char <= next_item.last_char;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(40, 1);
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: result check and stall pattern
    int     rx_cycle = 0;
    int     results_seen = 0;
    int     holdoff_left = 0;
    logic   holdoff_done = 1'b0;
    class_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            rx_cycle     = 0;
            holdoff_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (class_expected.size() == 0)
                begin
                    $display("%0t: unexpected class item, expected none actual %0d",
                             $realtime, literal_class);
                    error_count++;
                end
                else
                begin
                    want = class_expected.pop_front();
                    if (literal_class !== want)
                    begin
                        $display("%0t: literal_class mismatch, expected %0d actual %0d",
                                 $realtime, want, literal_class);
                        error_count++;
                    end
                end
            end
            rx_cycle++;
            // one long hold-off so the input side backs up
            if (!holdoff_done && results_seen >= HOLDOFF_AFTER)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle >> 7) % 4)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(1, 0));
                    2: out_ready <= ($urandom_range(3, 0) == 0);
                    default: out_ready <= ((rx_cycle % 8) != 0);
                endcase
            end
        end
    end

    // watchdog on cycles with no accepted item on either side
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("numeric_literal_classifier_top test failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        clear_literal_state();
        fill_stimulus();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (text_stream.size() > 0 || in_valid)
            @(posedge clk);
        while (class_expected.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (class_expected.size() != 0)
        begin
            $display("%0t: %0d class items never arrived", $realtime, class_expected.size());
            error_count++;
        end
        if (error_count == 0)
            $display("numeric_literal_classifier_top test passed");
        else
            $display("numeric_literal_classifier_top test failed");
        $finish;
    end

endmodule
